// ----- hdl/umric_pkg.sv -----
// Shared types and constants for the UM-32 register instruction core.
package umric_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned REG_CNT  = 8;
	localparam int unsigned REG_AW   = 3;
	localparam int unsigned IMM_W    = 25;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned STAT_W   = 3;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned CNT_W    = 5;

	localparam int unsigned S_DATA_W = 40;
	localparam int unsigned M_DATA_W = 48;

	// result status codes
	localparam logic [STAT_W-1:0] ST_DONE  = 3'd0;
	localparam logic [STAT_W-1:0] ST_OUT   = 3'd1;
	localparam logic [STAT_W-1:0] ST_HALT  = 3'd2;
	localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNSUP = 3'd4;
	localparam logic [STAT_W-1:0] ST_OVER  = 3'd5;

	typedef enum logic [3:0] {
		OP_CMOV  = 4'd0,
		OP_SLOAD = 4'd1,
		OP_SSTOR = 4'd2,
		OP_ADD   = 4'd3,
		OP_MUL   = 4'd4,
		OP_DIV   = 4'd5,
		OP_NAND  = 4'd6,
		OP_HALT  = 4'd7,
		OP_MAP   = 4'd8,
		OP_UNMAP = 4'd9,
		OP_OUT   = 4'd10,
		OP_IN    = 4'd11,
		OP_LOADP = 4'd12,
		OP_LOADV = 4'd13
	} umric_op_t;

	typedef enum logic [1:0] {
		SM_IDLE,
		SM_EXEC,
		SM_DIV,
		SM_FIN
	} umric_state_t;

endpackage

// ----- hdl/umric_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
module umric_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/um_register_instruction_core.sv -----
// Top level of the UM-32 register instruction core.
// Each accepted word is one machine instruction and yields exactly one result word. The eight
// registers live in two copies of a synchronous RAM (one per source operand) with registered
// read data; a valid bit per register, cleared by reset, makes an unwritten register read as
// zero, so no clearing pass follows reset. An instruction passes through RAM read, execute
// and write back before the next one can be accepted; a divide with a nonzero divisor also
// passes through the radix-2 restoring divider, which retires one quotient bit per cycle.
// A finished result waits in the output register while the next instruction is taken.
module um_register_instruction_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [31:0] instruction, [39:32] in_byte
	input  logic [umric_pkg::S_DATA_W-1:0]     s_tdata,
	// [0] in_end
	input  logic                               s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [7:0] out_byte, [8] wrote_reg, [11:9] dest_reg, [43:12] dest_value, [47:44] zero
	output logic [umric_pkg::M_DATA_W-1:0]     m_tdata,
	// [2:0] status
	output logic [umric_pkg::STAT_W-1:0]       m_tuser
);

	import umric_pkg::*;

	umric_state_t state_q, state_nxt;

	logic [WORD_W-1:0]  instr_q;
	logic [BYTE_W-1:0]  in_byte_q;
	logic               in_end_q;
	logic               halted_q;
	logic [REG_CNT-1:0] valid_q;

	logic [STAT_W-1:0]  res_st_q;
	logic [BYTE_W-1:0]  res_ob_q;
	logic               res_wr_q;
	logic [REG_AW-1:0]  res_dr_q;
	logic [WORD_W-1:0]  res_val_q;

	logic [WORD_W-1:0]  rem_q;
	logic [WORD_W-1:0]  dvs_q;
	logic [CNT_W-1:0]   cnt_q;

	logic               m_tvalid_q;
	logic [STAT_W-1:0]  m_st_q;
	logic [BYTE_W-1:0]  m_ob_q;
	logic               m_wr_q;
	logic [REG_AW-1:0]  m_dr_q;
	logic [WORD_W-1:0]  m_val_q;

	logic [WORD_W-1:0]  rd_b, rd_c, vb, vc;
	logic [2*WORD_W-1:0] prod;
	logic [REG_AW-1:0]  ra, rb, rc, rd;
	umric_op_t          op;
	logic               accept, out_free, load_out, ram_we;
	logic               div_last;
	logic [WORD_W:0]    rem_sh, rem_diff;
	logic               q_bit;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign load_out = (state_q == SM_FIN) && out_free;
	assign ram_we   = load_out && res_wr_q;
	assign div_last = (cnt_q == CNT_W'(DIV_STEPS - 1));

	assign op = umric_op_t'(instr_q[31:28]);
	assign ra = instr_q[8:6];
	assign rb = instr_q[5:3];
	assign rc = instr_q[2:0];
	assign rd = instr_q[27:25];

	umric_ram #(.WIDTH(WORD_W), .DEPTH(REG_CNT)) u_ram_b (
		.clk   (clk),
		.we    (ram_we),
		.waddr (res_dr_q),
		.wdata (res_val_q),
		.raddr (s_tdata[5:3]),
		.rdata (rd_b)
	);

	umric_ram #(.WIDTH(WORD_W), .DEPTH(REG_CNT)) u_ram_c (
		.clk   (clk),
		.we    (ram_we),
		.waddr (res_dr_q),
		.wdata (res_val_q),
		.raddr (s_tdata[2:0]),
		.rdata (rd_c)
	);

	// unwritten registers read as zero
	assign vb   = valid_q[rb] ? rd_b : '0;
	assign vc   = valid_q[rc] ? rd_c : '0;
	assign prod = vb * vc;

	// restoring divide step
	assign rem_sh   = {rem_q, res_val_q[WORD_W-1]};
	assign rem_diff = rem_sh - {1'b0, dvs_q};
	assign q_bit    = !rem_diff[WORD_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SM_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		s_tready  = 1'b0;
		case (state_q)
			SM_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_nxt = SM_EXEC;
				end
			end
			SM_EXEC: begin
				if (!halted_q && op == OP_DIV && vc != '0) begin
					state_nxt = SM_DIV;
				end else begin
					state_nxt = SM_FIN;
				end
			end
			SM_DIV: begin
				if (div_last) begin
					state_nxt = SM_FIN;
				end
			end
			SM_FIN: begin
				if (out_free) begin
					state_nxt = SM_IDLE;
				end
			end
			default: state_nxt = SM_IDLE;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			halted_q   <= 1'b0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (state_q == SM_EXEC && op == OP_HALT) begin
				halted_q <= 1'b1;
			end
			if (ram_we) begin
				valid_q[res_dr_q] <= 1'b1;
			end
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_q   <= s_tdata[31:0];
			in_byte_q <= s_tdata[39:32];
			in_end_q  <= s_tuser;
		end
		if (state_q == SM_EXEC) begin
			res_st_q  <= ST_DONE;
			res_ob_q  <= '0;
			res_wr_q  <= 1'b0;
			res_dr_q  <= '0;
			res_val_q <= '0;
			if (halted_q) begin
				res_st_q <= ST_HALT;
			end else begin
				case (op)
					OP_CMOV: begin
						if (vc != '0) begin
							res_wr_q  <= 1'b1;
							res_dr_q  <= ra;
							res_val_q <= vb;
						end
					end
					OP_ADD: begin
						res_wr_q  <= 1'b1;
						res_dr_q  <= ra;
						res_val_q <= vb + vc;
					end
					OP_MUL: begin
						res_wr_q  <= 1'b1;
						res_dr_q  <= ra;
						res_val_q <= prod[WORD_W-1:0];
					end
					OP_DIV: begin
						if (vc == '0) begin
							res_st_q <= ST_DIVZ;
						end else begin
							// load dividend; quotient shifts in behind it
							res_wr_q  <= 1'b1;
							res_dr_q  <= ra;
							res_val_q <= vb;
						end
					end
					OP_NAND: begin
						res_wr_q  <= 1'b1;
						res_dr_q  <= ra;
						res_val_q <= ~(vb & vc);
					end
					OP_HALT: begin
						res_st_q <= ST_HALT;
					end
					OP_OUT: begin
						if (vc[WORD_W-1:BYTE_W] != '0) begin
							res_st_q <= ST_OVER;
						end else begin
							res_st_q <= ST_OUT;
							res_ob_q <= vc[BYTE_W-1:0];
						end
					end
					OP_IN: begin
						res_wr_q  <= 1'b1;
						res_dr_q  <= rc;
						res_val_q <= in_end_q ? '1 : {{(WORD_W-BYTE_W){1'b0}}, in_byte_q};
					end
					OP_LOADV: begin
						res_wr_q  <= 1'b1;
						res_dr_q  <= rd;
						res_val_q <= {{(WORD_W-IMM_W){1'b0}}, instr_q[IMM_W-1:0]};
					end
					default: begin
						res_st_q <= ST_UNSUP;
					end
				endcase
			end
			rem_q <= '0;
			dvs_q <= vc;
			cnt_q <= '0;
		end else if (state_q == SM_DIV) begin
			rem_q     <= q_bit ? rem_diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
			res_val_q <= {res_val_q[WORD_W-2:0], q_bit};
			cnt_q     <= cnt_q + CNT_W'(1);
		end
		if (load_out) begin
			m_st_q  <= res_st_q;
			m_ob_q  <= res_ob_q;
			m_wr_q  <= res_wr_q;
			m_dr_q  <= res_dr_q;
			m_val_q <= res_val_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_st_q;
	assign m_tdata  = {{(M_DATA_W-WORD_W-REG_AW-1-BYTE_W){1'b0}}, m_val_q, m_dr_q, m_wr_q,
		m_ob_q};

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == SM_EXEC)
		else $error("accepted word did not enter execute");

	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halted state cleared without reset");

	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == SM_DIV && div_last |=> state_q == SM_FIN)
		else $error("divider overran its step count");

	a_halt_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		load_out && res_st_q == ST_HALT |-> !ram_we)
		else $error("register written on halt result");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && !m_tready |=> !$past(load_out) || $past(m_tvalid_q) == 1'b0)
		else $error("pending result overwritten");

endmodule

// ----- bench/um_register_instruction_core_tb.sv -----
// Self-checking bench for the UM-32 register instruction core: a predictor, a stream driver and a monitor.
module um_register_instruction_core_tb;
	import umric_pkg::*;

	localparam logic [3:0] OP_RSV14 = 4'd14;
	localparam logic [3:0] OP_RSV15 = 4'd15;
	localparam logic [3:0] UNSUP_OPS [7] = '{OP_SLOAD, OP_SSTOR, OP_MAP, OP_UNMAP, OP_LOADP,
		OP_RSV14, OP_RSV15};
	localparam int unsigned IMM_MAX = (1 << IMM_W) - 1;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic [WORD_W-1:0] word;
		logic [BYTE_W-1:0] in_char;
		logic              in_end;
	} instr_item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [BYTE_W-1:0] out_byte;
		logic              wrote;
		logic [REG_AW-1:0] dest;
		logic [WORD_W-1:0] value;
	} exec_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [S_DATA_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0] m_tuser;

	um_register_instruction_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// predicted machine state
	logic [WORD_W-1:0] model_regs [REG_CNT];
	logic model_halted;

	instr_item_t instr_q [$];
	exec_result_t pending_results [$];
	instr_item_t drv_item;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int words_queued = 0;
	int words_accepted = 0;
	int results_checked = 0;
	int mismatch_cnt = 0;
	int status_seen [8];

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("um_register_instruction_core verification failed");
		$finish;
	end

	// Execute one word against the predicted registers.
	function automatic exec_result_t exec_instr(instr_item_t it);
		exec_result_t r;
		logic [3:0] op;
		logic [REG_AW-1:0] ra, rb, rc, rd;
		logic [WORD_W-1:0] vb, vc, v;
		op = it.word[31:28];
		ra = it.word[8:6];
		rb = it.word[5:3];
		rc = it.word[2:0];
		rd = it.word[27:25];
		vb = model_regs[rb];
		vc = model_regs[rc];
		r = '{ST_DONE, '0, 1'b0, '0, '0};
		if (model_halted) begin
			r.status = ST_HALT;
			return r;
		end
		case (op)
			OP_CMOV: begin
				if (vc != 0) begin
					r.wrote = 1'b1; r.dest = ra; r.value = vb;
				end
			end
			OP_ADD: begin
				r.wrote = 1'b1; r.dest = ra; r.value = vb + vc;
			end
			OP_MUL: begin
				r.wrote = 1'b1; r.dest = ra; r.value = vb * vc;
			end
			OP_DIV: begin
				if (vc == 0) r.status = ST_DIVZ;
				else begin
					r.wrote = 1'b1; r.dest = ra; r.value = vb / vc;
				end
			end
			OP_NAND: begin
				r.wrote = 1'b1; r.dest = ra; r.value = ~(vb & vc);
			end
			OP_HALT: begin
				model_halted = 1'b1;
				r.status = ST_HALT;
			end
			OP_OUT: begin
				if (vc > 255) r.status = ST_OVER;
				else begin
					r.status = ST_OUT; r.out_byte = vc[BYTE_W-1:0];
				end
			end
			OP_IN: begin
				v = it.in_end ? '1 : {{(WORD_W-BYTE_W){1'b0}}, it.in_char};
				r.wrote = 1'b1; r.dest = rc; r.value = v;
			end
			OP_LOADV: begin
				v = {{(WORD_W-IMM_W){1'b0}}, it.word[IMM_W-1:0]};
				r.wrote = 1'b1; r.dest = rd; r.value = v;
			end
			default: r.status = ST_UNSUP;
		endcase
		if (r.wrote) model_regs[r.dest] = r.value;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] abc_word(logic [3:0] op, logic [2:0] a, logic [2:0] b,
		logic [2:0] c);
		logic [WORD_W-1:0] w;
		w = $urandom();
		w[31:28] = op;
		w[8:6] = a;
		w[5:3] = b;
		w[2:0] = c;
		return w;
	endfunction

	function automatic logic [WORD_W-1:0] loadv_word(logic [2:0] rd, logic [IMM_W-1:0] imm);
		return {OP_LOADV, rd, imm};
	endfunction

	task automatic push_word(logic [WORD_W-1:0] w, logic [BYTE_W-1:0] ch, logic e);
		instr_item_t it;
		it.word = w;
		it.in_char = ch;
		it.in_end = e;
		instr_q.push_back(it);
		words_queued++;
	endtask

	task automatic push_rand(logic [WORD_W-1:0] w);
		push_word(w, BYTE_W'($urandom()), $urandom_range(3) == 0);
	endtask

	// Mostly well-formed programs: plenty of loads keep register contents varied, small values
	// make output and divide-by-zero reachable.
	task automatic add_random(int n);
		int sel;
		logic [2:0] a, b, c;
		logic [IMM_W-1:0] imm;
		for (int i = 0; i < n; i++) begin
			sel = $urandom_range(99);
			a = REG_AW'($urandom());
			b = REG_AW'($urandom());
			c = REG_AW'($urandom());
			if (sel < 20) begin
				case ($urandom_range(3))
					0: imm = '0;
					1: imm = IMM_W'($urandom_range(300));
					2: imm = IMM_W'($urandom());
					default: imm = IMM_W'(IMM_MAX - $urandom_range(1));
				endcase
				push_rand(loadv_word(a, imm));
			end else if (sel < 28) push_rand(abc_word(OP_IN, a, b, c));
			else if (sel < 38) push_rand(abc_word(OP_OUT, a, b, c));
			else if (sel < 46) push_rand(abc_word(OP_CMOV, a, b, c));
			else if (sel < 54) push_rand(abc_word(OP_ADD, a, b, c));
			else if (sel < 62) push_rand(abc_word(OP_MUL, a, b, c));
			else if (sel < 74) push_rand(abc_word(OP_DIV, a, b, c));
			else if (sel < 84) push_rand(abc_word(OP_NAND, a, b, c));
			else push_rand(abc_word(UNSUP_OPS[$urandom_range(6)], a, b, c));
		end
	endtask

	task automatic add_directed();
		push_word(32'h0000_0000, 8'h00, 1'b0);
		push_rand(loadv_word(3'd7, IMM_W'(IMM_MAX)));
		push_rand(loadv_word(3'd1, 25'd255));
		push_rand(loadv_word(3'd2, 25'd256));
		push_word(abc_word(OP_IN, 3'd0, 3'd0, 3'd3), 8'h5a, 1'b1);
		push_word(abc_word(OP_IN, 3'd0, 3'd0, 3'd4), 8'hff, 1'b0);
		push_word(abc_word(OP_IN, 3'd0, 3'd0, 3'd5), 8'h00, 1'b0);
		push_rand(abc_word(OP_ADD, 3'd6, 3'd3, 3'd3));
		push_rand(abc_word(OP_MUL, 3'd6, 3'd3, 3'd7));
		push_rand(abc_word(OP_DIV, 3'd5, 3'd3, 3'd1));
		push_rand(abc_word(OP_DIV, 3'd6, 3'd3, 3'd0));
		push_rand(abc_word(OP_CMOV, 3'd5, 3'd7, 3'd0));
		push_rand(abc_word(OP_CMOV, 3'd5, 3'd7, 3'd1));
		push_rand(abc_word(OP_NAND, 3'd0, 3'd0, 3'd0));
		push_rand(abc_word(OP_NAND, 3'd6, 3'd3, 3'd3));
		push_rand(abc_word(OP_OUT, 3'd0, 3'd0, 3'd1));
		push_rand(abc_word(OP_OUT, 3'd0, 3'd0, 3'd2));
		push_rand(abc_word(OP_OUT, 3'd0, 3'd0, 3'd6));
		foreach (UNSUP_OPS[i]) push_rand(abc_word(UNSUP_OPS[i], 3'd0, 3'd0, 3'd0));
		push_word(32'hffff_ffff, 8'hff, 1'b1);
	endtask

	task automatic wait_drained();
		while (words_accepted != words_queued || pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_result();
		exec_result_t exp_r;
		exec_result_t got;
		got.status = m_tuser;
		got.out_byte = m_tdata[7:0];
		got.wrote = m_tdata[8];
		got.dest = m_tdata[11:9];
		got.value = m_tdata[43:12];
		status_seen[got.status]++;
		if (pending_results.size() == 0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display("unexpected result word: status %0d data %h", m_tuser, m_tdata);
			return;
		end
		exp_r = pending_results.pop_front();
		results_checked++;
		if (got != exp_r || m_tdata[47:44] != 4'd0) begin
			mismatch_cnt++;
			if (mismatch_cnt <= MAX_REPORTS)
				$display({"result %0d mismatch: exp st=%0d ob=%h wr=%b rd=%0d val=%h,",
					" got st=%0d ob=%h wr=%b rd=%0d val=%h pad=%h"}, results_checked,
					exp_r.status, exp_r.out_byte, exp_r.wrote, exp_r.dest, exp_r.value,
					got.status, got.out_byte, got.wrote, got.dest, got.value,
					m_tdata[47:44]);
		end
	endtask

	// driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pending_results.push_back(exec_instr(drv_item));
				words_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (instr_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					drv_item = instr_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= {drv_item.in_char, drv_item.word};
					s_tuser <= drv_item.in_end;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: check each accepted result word, stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) check_result();
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		foreach (model_regs[i]) model_regs[i] = '0;
		model_halted = 1'b0;
		foreach (status_seen[i]) status_seen[i] = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		add_directed();
		add_random(150);
		wait_drained();

		send_idle_pct = 79;
		add_random(150);
		wait_drained();

		send_idle_pct = 0;
		recv_stall_pct = 79;
		add_random(150);
		wait_drained();

		send_idle_pct = 29;
		recv_stall_pct = 29;
		add_random(150);
		wait_drained();

		// halt is sticky until reset, so it closes the run; everything after must report halted
		push_rand(abc_word(OP_HALT, REG_AW'($urandom()), REG_AW'($urandom()),
			REG_AW'($urandom())));
		add_random(12);
		wait_drained();
		repeat (40) @(posedge clk);

		$display("ran %0d instructions, checked %0d results in five idle/stall phases",
			words_accepted, results_checked);
		$display("status counts done=%0d out=%0d halt=%0d divz=%0d unsup=%0d over=%0d",
			status_seen[ST_DONE], status_seen[ST_OUT], status_seen[ST_HALT],
			status_seen[ST_DIVZ], status_seen[ST_UNSUP], status_seen[ST_OVER]);
		if (mismatch_cnt > MAX_REPORTS)
			$display("%0d mismatches in total", mismatch_cnt);
		if (mismatch_cnt == 0 && pending_results.size() == 0) begin
			$display("um_register_instruction_core verification clean");
		end else begin
			$display("um_register_instruction_core verification failed");
		end
		$finish;
	end

endmodule
